/* sv/ts_psr_pkg.sv */
// ----------------------------------------------------------------------------
// ts_psr_pkg
// Shared types and constants of the transport stream PID split router.
// ----------------------------------------------------------------------------
package ts_psr_pkg;

    // Default sizes of the PID store and the output set.
    localparam int NUM_PIDS_DEF    = 8192;
    localparam int NUM_OUTPUTS_DEF = 16;

    // Field widths fixed by the item format.
    localparam int PID_W   = 13;
    localparam int OIDX_W  = 4;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;
    localparam int HDR_W   = 8;
    localparam int PID_HI_W = PID_W - HDR_W;

    // Widest mask that the 4-bit output index can address.
    localparam int MASK_MAX = 1 << OIDX_W;

    // Depth of the queue between classifier and executor.
    localparam int QUEUE_DEPTH = 2;

    // Operation codes of an input item.
    typedef enum logic [OP_W-1:0] {
        OP_PACKET      = 2'd0,
        OP_SUBSCRIBE   = 2'd1,
        OP_UNSUBSCRIBE = 2'd2
    } op_t;

    // Kinds of result item.
    typedef enum logic [KIND_W-1:0] {
        KIND_DELIVER = 2'd0,
        KIND_ADDED   = 2'd1,
        KIND_REMOVED = 2'd2
    } kind_t;

    // A classified command as it travels through the queue.
    typedef struct packed {
        op_t               op;
        logic [PID_W-1:0]  pid;
        logic [OIDX_W-1:0] oidx;
    } cmd_t;

endpackage

/* sv/ts_psr_front.sv */
// ----------------------------------------------------------------------------
// ts_psr_front
// Accepts input items, decodes the operation and the PID, and drops items
// that can never cause a result before they reach the queue.
// ----------------------------------------------------------------------------
module ts_psr_front
    import ts_psr_pkg::*;
#(
    parameter int NUM_PIDS    = NUM_PIDS_DEF,
    parameter int NUM_OUTPUTS = NUM_OUTPUTS_DEF
)
(
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [OP_W-1:0]   op,
    input  logic [HDR_W-1:0]  header_hi,
    input  logic [HDR_W-1:0]  header_lo,
    input  logic [PID_W-1:0]  pid,
    input  logic [OIDX_W-1:0] output_index,
    output logic              push_valid,
    output cmd_t              push_data,
    input  logic              push_ready
);

    logic             accept;
    logic [PID_W-1:0] hdr_pid;
    logic [PID_W-1:0] sel_pid;
    logic             is_packet;
    logic             is_sub;
    logic             pid_ok;
    logic             oidx_ok;
    logic             keep;

    // The input side waits only when the queue is full.
    assign item_stall = !push_ready;
    assign accept     = item_valid && push_ready;

    // PID of a packet is the low five bits of header_hi above all eight bits of header_lo.
    assign hdr_pid = {header_hi[PID_HI_W-1:0], header_lo};

    assign is_packet = (op == OP_PACKET);
    assign is_sub    = (op == OP_SUBSCRIBE) || (op == OP_UNSUBSCRIBE);
    assign sel_pid   = is_packet ? hdr_pid : pid;

    // Range checks against the configured store and output count.
    assign pid_ok  = {1'b0, sel_pid} < (PID_W + 1)'(NUM_PIDS);
    assign oidx_ok = 7'(output_index) < 7'(NUM_OUTPUTS);

    // Unknown codes and out-of-range items cause no result at all.
    assign keep = pid_ok && (is_packet || (is_sub && oidx_ok));

    assign push_valid     = accept && keep;
    assign push_data.op   = op_t'(op);
    assign push_data.pid  = sel_pid;
    assign push_data.oidx = output_index;

endmodule

/* sv/ts_psr_queue.sv */
// ----------------------------------------------------------------------------
// ts_psr_queue
// Short command queue that decouples the classifier from the executor.
// ----------------------------------------------------------------------------
module ts_psr_queue
    import ts_psr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_data,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_data,
    input  logic pop
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_t           slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = count_reg != (QAW + 1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots carry no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/ts_psr_back.sv */
// ----------------------------------------------------------------------------
// ts_psr_back
// Executes queued commands against the subscriber mask memory and drives
// the result channel through an output register.
// ----------------------------------------------------------------------------
module ts_psr_back
    import ts_psr_pkg::*;
#(
    parameter int NUM_PIDS    = NUM_PIDS_DEF,
    parameter int NUM_OUTPUTS = NUM_OUTPUTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  cmd_t              q_data,
    output logic              q_pop,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [KIND_W-1:0] kind,
    output logic [OIDX_W-1:0] dest,
    output logic [PID_W-1:0]  pid_out,
    output logic              last
);

    localparam int MASK_W = (NUM_OUTPUTS < MASK_MAX) ? NUM_OUTPUTS : MASK_MAX;
    localparam int PID_AW = $clog2(NUM_PIDS);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [PID_AW-1:0]   clr_addr_reg;
    logic [PID_AW-1:0]   clr_addr_next;
    cmd_t                cmd_reg;
    logic [MASK_W-1:0]   rem_reg;
    logic [MASK_W-1:0]   rem_next;
    logic [MASK_W-1:0]   mask_mem [NUM_PIDS];
    logic [MASK_W-1:0]   rd_data_reg;

    logic                mem_we;
    logic [PID_AW-1:0]   mem_waddr;
    logic [MASK_W-1:0]   mem_wdata;
    logic                mem_re;

    logic                out_valid_reg;
    kind_t               kind_reg;
    logic [OIDX_W-1:0]   dest_reg;
    logic [PID_W-1:0]    pid_reg;
    logic                last_reg;
    logic                out_free;
    logic                out_load;
    kind_t               load_kind;
    logic [OIDX_W-1:0]   load_dest;
    logic                load_last;

    logic [MASK_W-1:0]   bit_sel;
    logic [MASK_W-1:0]   after_mask;
    logic                ev_added;
    logic                ev_removed;
    logic [MASK_W-1:0]   rem_rest;
    logic [OIDX_W-1:0]   low_idx;

    assign out_free = !out_valid_reg || !result_stall;

    // Decision on a subscribe or unsubscribe once the old mask is in.
    assign bit_sel    = MASK_W'(1) << cmd_reg.oidx;
    assign after_mask = (cmd_reg.op == OP_SUBSCRIBE) ? (rd_data_reg | bit_sel)
                                                     : (rd_data_reg & ~bit_sel);
    assign ev_added   = (rd_data_reg == '0) && (after_mask != '0);
    assign ev_removed = (rd_data_reg != '0) && (after_mask == '0);

    // Lowest pending subscriber and the mask left after it.
    assign rem_rest = rem_reg & (rem_reg - 1'b1);
    always_comb
    begin
        low_idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (rem_reg[i])
            begin
                low_idx = OIDX_W'(i);
            end
        end
    end

    // Sequencer: clearing pass, read, execute, then deliveries one a cycle while the output register is free.
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        rem_next      = rem_reg;
        q_pop         = 1'b0;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = cmd_reg.pid[PID_AW-1:0];
        mem_wdata     = after_mask;
        out_load      = 1'b0;
        load_kind     = KIND_DELIVER;
        load_dest     = '0;
        load_last     = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == PID_AW'(NUM_PIDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    mem_re     = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd_reg.op == OP_PACKET)
                begin
                    rem_next   = rd_data_reg;
                    state_next = (rd_data_reg == '0) ? ST_IDLE : ST_EMIT;
                end
                else if (!(ev_added || ev_removed) || out_free)
                begin
                    mem_we     = 1'b1;
                    out_load   = ev_added || ev_removed;
                    load_kind  = ev_added ? KIND_ADDED : KIND_REMOVED;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    load_dest = low_idx;
                    load_last = (rem_rest == '0);
                    rem_next  = rem_rest;
                    if (rem_rest == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Command, scan mask and result payload registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (q_pop)
        begin
            cmd_reg <= q_data;
        end
        if (out_load)
        begin
            kind_reg <= load_kind;
            dest_reg <= load_dest;
            pid_reg  <= cmd_reg.pid;
            last_reg <= load_last;
        end
    end

    // Subscriber mask memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mask_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mask_mem[q_data.pid[PID_AW-1:0]];
        end
    end

    assign result_valid = out_valid_reg;
    assign kind         = kind_reg;
    assign dest         = dest_reg;
    assign pid_out      = pid_reg;
    assign last         = last_reg;

    // No command leaves the queue while the store is being cleared.
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !q_pop)
        else $error("command taken during clearing pass");

    // A delivery run always has a subscriber left to send.
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (rem_reg != '0))
        else $error("delivery state with empty mask");

    // A result is loaded only into a free output register.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result overwrote a pending item");

    // The mask store is never written while deliveries go out.
    a_no_write_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !mem_we)
        else $error("mask write during delivery");

    // The last delivery of a packet returns the executor to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_load && load_last) |=> (state_reg == ST_IDLE))
        else $error("executor did not finish after last delivery");

endmodule

/* sv/ts_pid_split_router.sv */
// ----------------------------------------------------------------------------
// ts_pid_split_router
// Routes transport stream packet headers by PID to subscribed outputs and
// maintains per-PID subscriber masks.
//
//   Channel   Handshake                  Payload
//   item      item_valid / item_stall    op, header_hi, header_lo, pid,
//                                        output_index
//   result    result_valid / result_stall kind, dest, pid_out, last
//
// A packet passes the executor's idle (read) and execute states, then, if it
// has subscribers, gives one delivery per cycle per subscribed output while
// result_stall is low; a subscribe or unsubscribe passes idle and execute.
// After reset a clearing pass writes every mask entry, one per cycle;
// items queue up and then stall meanwhile.
// A two-entry queue lets the input side keep going while results stall.
// ----------------------------------------------------------------------------
module ts_pid_split_router
    import ts_psr_pkg::*;
#(
    parameter int NUM_PIDS    = NUM_PIDS_DEF,
    parameter int NUM_OUTPUTS = NUM_OUTPUTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [OP_W-1:0]   op,
    input  logic [HDR_W-1:0]  header_hi,
    input  logic [HDR_W-1:0]  header_lo,
    input  logic [PID_W-1:0]  pid,
    input  logic [OIDX_W-1:0] output_index,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [KIND_W-1:0] kind,
    output logic [OIDX_W-1:0] dest,
    output logic [PID_W-1:0]  pid_out,
    output logic              last
);

    logic push_valid;
    cmd_t push_data;
    logic push_ready;
    logic q_valid;
    cmd_t q_data;
    logic q_pop;

    // Classifier.
    ts_psr_front #(
        .NUM_PIDS    (NUM_PIDS),
        .NUM_OUTPUTS (NUM_OUTPUTS)
    ) u_front (
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .header_hi    (header_hi),
        .header_lo    (header_lo),
        .pid          (pid),
        .output_index (output_index),
        .push_valid   (push_valid),
        .push_data    (push_data),
        .push_ready   (push_ready)
    );

    // Command queue.
    ts_psr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_data),
        .pop        (q_pop)
    );

    // Executor with the mask store.
    ts_psr_back #(
        .NUM_PIDS    (NUM_PIDS),
        .NUM_OUTPUTS (NUM_OUTPUTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .dest         (dest),
        .pid_out      (pid_out),
        .last         (last)
    );

endmodule
